>>> rtl/frga_pkg.sv
// Package with shared types, codes and constants of the font ROM glyph address generator.
`default_nettype none

package frga_pkg;

	localparam int unsigned ADDR_W  = 24;
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned CODE_W  = 16;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned OFF_W   = 5;

	// Lookup kinds carried in the command field.
	localparam logic [CMD_W-1:0] CMD_HANZI_15X16 = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HANZI_11X12 = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ASCII_8X16  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ASCII_6X12  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ASCII_5X7   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_GB_TO_UNI   = 3'd5;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_HANZI_15X16 = 3'd0;
	localparam logic [2:0] REG_HANZI_11X12 = 3'd1;
	localparam logic [2:0] REG_ASCII_8X16  = 3'd2;
	localparam logic [2:0] REG_ASCII_6X12  = 3'd3;
	localparam logic [2:0] REG_ASCII_5X7   = 3'd4;
	localparam logic [2:0] REG_GB_TO_UNI   = 3'd5;

	localparam logic [ADDR_W-1:0] RST_HANZI_15X16 = 24'd0;
	localparam logic [ADDR_W-1:0] RST_HANZI_11X12 = 24'd249728;
	localparam logic [ADDR_W-1:0] RST_ASCII_8X16  = 24'd243648;
	localparam logic [ADDR_W-1:0] RST_ASCII_6X12  = 24'd421184;
	localparam logic [ADDR_W-1:0] RST_ASCII_5X7   = 24'd245696;
	localparam logic [ADDR_W-1:0] RST_GB_TO_UNI   = 24'd12032;

	localparam logic [7:0] READ_OPCODE = 8'h03;

	// GB2312 code ranges.
	localparam logic [7:0] GB_LO_FIRST   = 8'hA1;
	localparam logic [7:0] GB_SYM_FIRST  = 8'hA1;
	localparam logic [7:0] GB_SYM3_LAST  = 8'hA3;
	localparam logic [7:0] GB_BLANK_FIRST = 8'hA4;
	localparam logic [7:0] GB_BLANK_LAST = 8'hA8;
	localparam logic [7:0] GB_SYM9_ROW   = 8'hA9;
	localparam logic [7:0] GB_HZ_FIRST   = 8'hB0;
	localparam logic [7:0] GB_HZ_LAST    = 8'hF7;
	localparam logic [7:0] GB_A9_LO_LAST = 8'hF6;
	localparam logic [7:0] ASCII_FIRST   = 8'h20;
	localparam logic [7:0] ASCII_LAST    = 8'h7E;

	localparam int unsigned SLOT_W       = 13;
	localparam logic [SLOT_W-1:0] ROW_LEN      = 13'd94;
	localparam logic [SLOT_W-1:0] SKIP_15X16   = 13'd846;
	localparam logic [SLOT_W-1:0] SKIP_11X12   = 13'd376;
	localparam logic [SLOT_W-1:0] SKIP_TABLE   = 13'd368;
	localparam logic [SLOT_W-1:0] ROW_A9_SLOT  = 13'd282;

	localparam logic [COUNT_W-1:0] CNT_15X16 = 6'd32;
	localparam logic [COUNT_W-1:0] CNT_11X12 = 6'd24;
	localparam logic [COUNT_W-1:0] CNT_8X16  = 6'd16;
	localparam logic [COUNT_W-1:0] CNT_6X12  = 6'd12;
	localparam logic [COUNT_W-1:0] CNT_5X7   = 6'd8;
	localparam logic [COUNT_W-1:0] CNT_TABLE = 6'd2;
	localparam logic [OFF_W-1:0]   OFF_SECOND = 5'd16;

	typedef struct packed {
		logic               found;
		logic [31:0]        spi_command;
		logic [COUNT_W-1:0] byte_count;
		logic [OFF_W-1:0]   dest_offset;
		logic               last;
	} result_t;

	function automatic result_t frga_read(input logic [ADDR_W-1:0] addr,
		input logic [COUNT_W-1:0] count, input logic [OFF_W-1:0] off, input logic last);
		result_t r;
		r.found       = 1'b1;
		r.spi_command = {READ_OPCODE, addr};
		r.byte_count  = count;
		r.dest_offset = off;
		r.last        = last;
		return r;
	endfunction

	function automatic result_t frga_none();
		result_t r;
		r = '0;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/frga_if.sv
// Request and result channel interfaces of the font ROM glyph address generator.
`default_nettype none

interface frga_req_if;
	import frga_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CODE_W-1:0] char_code;

	modport source (output valid, output command, output char_code, input ready);
	modport sink (input valid, input command, input char_code, output ready);
endinterface

interface frga_rsp_if;
	import frga_pkg::*;

	logic               valid;
	logic               ready;
	logic               found;
	logic [31:0]        spi_command;
	logic [COUNT_W-1:0] byte_count;
	logic [OFF_W-1:0]   dest_offset;
	logic               last;

	modport source (output valid, output found, output spi_command, output byte_count,
		output dest_offset, output last, input ready);
	modport sink (input valid, input found, input spi_command, input byte_count,
		input dest_offset, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/font_rom_glyph_address_generator_top.sv
// Top level of the font ROM glyph address generator: request register, address logic, result buffer.
//
// Each request on cmd_req carries a lookup kind and a character code. The block answers
// on rsp with one or two serial-flash read commands (opcode 0x03 and a 24-bit ROM address)
// with byte count and glyph buffer offset; last marks the final result of a request.
// Hanzi lookups read GB2312 codes outside the symbol and hanzi rows as two 8x16 ASCII glyphs, one per
// byte, placed at offsets 0 and 16. Unprintable or unsupported codes give one not-found result.
// The six ROM base addresses sit behind an APB-style port at byte addresses 0, 4, ... 20;
// writes complete in the access cycle and pready is tied high. Reads return the register.
// Each request passes through one register stage for the request and one for its results.
// Throughput: one request per cycle when each gives a single result and rsp is not stalled;
// a fallback request holds the result buffer until both results are taken, as rsp shows one slot at a time.
// If the receiver stalls, the result buffer holds its results and one more request can be
// taken into the request register; after that cmd_req.ready drops until rsp moves again.
// Reset clears both stages and loads the base registers with their default ROM layout.
`default_nettype none

module font_rom_glyph_address_generator_top (
	input  wire                           clk,
	input  wire                           arst_n,
	frga_req_if.sink                      cmd_req,
	frga_rsp_if.source                    rsp,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [frga_pkg::PADDR_W-1:0]  paddr,
	input  wire  [frga_pkg::PDATA_W-1:0]  pwdata,
	output logic [frga_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import frga_pkg::*;

	// Base address registers.
	logic [ADDR_W-1:0] base_hz16_q, base_hz12_q, base_a16_q, base_a12_q, base_a7_q, base_uni_q;
	logic              cfg_wr;
	logic [2:0]        cfg_idx;

	// Request stage.
	logic              valid_s1;
	logic [CMD_W-1:0]  command_s1;
	logic [CODE_W-1:0] code_s1;
	logic              advance_s1;

	// Result stage: up to two results, idx_s2 selects the one shown.
	logic              valid_s2;
	logic              two_s2;
	logic              idx_s2;
	result_t           r0_s2, r1_s2;
	logic              free_s2;
	logic              rsp_take;

	// Address logic.
	logic [7:0]        hi, lo;
	logic              lo_ok, hi_print, lo_print;
	logic [3:0]        sym_row;
	logic [6:0]        hz_row, col;
	logic [SLOT_W-1:0] sym_slot, hz_slot, slot;
	logic [6:0]        a_hi, a_lo;
	logic              fb;
	logic              nx_two;
	result_t           nx_r0, nx_r1;

	// Configuration port: the register index is the word address.
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_hz16_q <= RST_HANZI_15X16;
			base_hz12_q <= RST_HANZI_11X12;
			base_a16_q  <= RST_ASCII_8X16;
			base_a12_q  <= RST_ASCII_6X12;
			base_a7_q   <= RST_ASCII_5X7;
			base_uni_q  <= RST_GB_TO_UNI;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_HANZI_15X16: base_hz16_q <= pwdata[ADDR_W-1:0];
				REG_HANZI_11X12: base_hz12_q <= pwdata[ADDR_W-1:0];
				REG_ASCII_8X16:  base_a16_q  <= pwdata[ADDR_W-1:0];
				REG_ASCII_6X12:  base_a12_q  <= pwdata[ADDR_W-1:0];
				REG_ASCII_5X7:   base_a7_q   <= pwdata[ADDR_W-1:0];
				REG_GB_TO_UNI:   base_uni_q  <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_HANZI_15X16: prdata = {8'd0, base_hz16_q};
			REG_HANZI_11X12: prdata = {8'd0, base_hz12_q};
			REG_ASCII_8X16:  prdata = {8'd0, base_a16_q};
			REG_ASCII_6X12:  prdata = {8'd0, base_a12_q};
			REG_ASCII_5X7:   prdata = {8'd0, base_a7_q};
			REG_GB_TO_UNI:   prdata = {8'd0, base_uni_q};
			default:         prdata = '0;
		endcase
	end

	// Handshake: the request register moves on whenever the result buffer is free
	// by the end of this cycle, so a single-result stream runs at full rate while rsp is ready.
	assign rsp_take   = rsp.valid && rsp.ready;
	assign free_s2    = !valid_s2 || (rsp.ready && (idx_s2 || !two_s2));
	assign advance_s1 = valid_s1 && free_s2;
	assign cmd_req.ready = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_req.ready) begin
			valid_s1 <= cmd_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_req.valid && cmd_req.ready) begin
			command_s1 <= cmd_req.command;
			code_s1    <= cmd_req.char_code;
		end
	end

	// Slot arithmetic: row times 94 plus column, then a per-kind skip for the hanzi rows.
	assign hi       = code_s1[15:8];
	assign lo       = code_s1[7:0];
	assign lo_ok    = lo >= GB_LO_FIRST;
	assign hi_print = hi >= ASCII_FIRST && hi <= ASCII_LAST;
	assign lo_print = lo >= ASCII_FIRST && lo <= ASCII_LAST;
	assign sym_row  = 4'(hi - GB_SYM_FIRST);
	assign hz_row   = 7'(hi - GB_HZ_FIRST);
	assign col      = 7'(lo - GB_LO_FIRST);
	assign sym_slot = SLOT_W'(13'(sym_row) * ROW_LEN) + 13'(col);
	assign hz_slot  = SLOT_W'(13'(hz_row) * ROW_LEN) + 13'(col);
	assign a_hi     = 7'(hi - ASCII_FIRST);
	assign a_lo     = 7'(lo - ASCII_FIRST);

	always_comb begin
		fb     = 1'b0;
		slot   = '0;
		nx_two = 1'b0;
		nx_r0  = frga_none();
		nx_r1  = frga_none();
		case (command_s1)
			CMD_HANZI_15X16: begin
				// Rows 0xA4..0xA8 are empty in this font and all map to slot 0.
				if (hi >= GB_BLANK_FIRST && hi <= GB_BLANK_LAST && lo_ok)
					slot = '0;
				else if (hi >= GB_SYM_FIRST && hi <= GB_SYM9_ROW && lo_ok)
					slot = sym_slot;
				else if (hi >= GB_HZ_FIRST && hi <= GB_HZ_LAST && lo_ok)
					slot = hz_slot + SKIP_15X16;
				else
					fb = 1'b1;
				nx_r0 = frga_read(base_hz16_q + ADDR_W'({slot, 5'd0}), CNT_15X16, '0, 1'b1);
			end
			CMD_HANZI_11X12: begin
				if (hi >= GB_SYM_FIRST && hi <= GB_SYM3_LAST && lo_ok)
					slot = sym_slot;
				else if (hi == GB_SYM9_ROW && lo_ok)
					slot = ROW_A9_SLOT + 13'(col);
				else if (hi >= GB_HZ_FIRST && hi <= GB_HZ_LAST && lo_ok)
					slot = hz_slot + SKIP_11X12;
				else
					fb = 1'b1;
				nx_r0 = frga_read(base_hz12_q + ADDR_W'({slot, 4'd0}) + ADDR_W'({slot, 3'd0}),
					CNT_11X12, '0, 1'b1);
			end
			CMD_ASCII_8X16: begin
				if (lo_print)
					nx_r0 = frga_read(base_a16_q + ADDR_W'({a_lo, 4'd0}), CNT_8X16, '0, 1'b1);
			end
			CMD_ASCII_6X12: begin
				if (lo_print)
					nx_r0 = frga_read(base_a12_q + ADDR_W'({a_lo, 3'd0}) + ADDR_W'({a_lo, 2'd0}),
						CNT_6X12, '0, 1'b1);
			end
			CMD_ASCII_5X7: begin
				if (lo_print)
					nx_r0 = frga_read(base_a7_q + ADDR_W'({a_lo, 3'd0}), CNT_5X7, '0, 1'b1);
			end
			CMD_GB_TO_UNI: begin
				// Codes outside the table still read entry 0.
				if (hi >= GB_SYM_FIRST && hi <= GB_SYM3_LAST && lo_ok)
					slot = sym_slot;
				else if (hi == GB_SYM9_ROW && lo_ok && lo <= GB_A9_LO_LAST)
					slot = ROW_A9_SLOT + 13'(col);
				else if (hi >= GB_HZ_FIRST && hi <= GB_HZ_LAST && lo_ok)
					slot = hz_slot + SKIP_TABLE;
				else
					slot = '0;
				nx_r0 = frga_read(base_uni_q + ADDR_W'({slot, 1'b0}), CNT_TABLE, '0, 1'b1);
			end
			default: nx_r0 = frga_none();
		endcase
		if (fb) begin
			if (hi_print && lo_print) begin
				nx_two = 1'b1;
				nx_r0  = frga_read(base_a16_q + ADDR_W'({a_hi, 4'd0}), CNT_8X16, '0, 1'b0);
				nx_r1  = frga_read(base_a16_q + ADDR_W'({a_lo, 4'd0}), CNT_8X16, OFF_SECOND, 1'b1);
			end else begin
				nx_r0 = frga_none();
			end
		end
	end

	// Result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			two_s2   <= 1'b0;
			idx_s2   <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= advance_s1;
			two_s2   <= nx_two;
			idx_s2   <= 1'b0;
		end else if (rsp_take) begin
			idx_s2 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			r0_s2 <= nx_r0;
			r1_s2 <= nx_r1;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.found       = idx_s2 ? r1_s2.found       : r0_s2.found;
	assign rsp.spi_command = idx_s2 ? r1_s2.spi_command : r0_s2.spi_command;
	assign rsp.byte_count  = idx_s2 ? r1_s2.byte_count  : r0_s2.byte_count;
	assign rsp.dest_offset = idx_s2 ? r1_s2.dest_offset : r0_s2.dest_offset;
	assign rsp.last        = idx_s2 ? r1_s2.last        : r0_s2.last;

`ifndef NO_ASSERTIONS
	// The second slot is only ever shown for a request that produced two results.
	a_second_slot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && idx_s2 |-> two_s2)
		else $error("second result shown for a single-result request");

	// A taken result that is not last is followed by the second fallback read.
	a_follow_up: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && !rsp.last |=> rsp.valid && rsp.found && rsp.dest_offset == OFF_SECOND)
		else $error("first fallback result not followed by the second");

	// A not-found result always ends its request and reads nothing.
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.last && rsp.byte_count == '0 && rsp.spi_command == '0)
		else $error("malformed not-found result");

	// A request held in the first stage keeps its contents until it moves on.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(command_s1) && $stable(code_s1))
		else $error("stalled request lost or changed");
`endif

endmodule

`default_nettype wire
